// ===== hdl/scfp_pkg.sv =====
// ---------------------------------------------------------------------------
// scfp_pkg: shared definitions of the checksummed frame parser
// Field widths, status codes, configuration indexes and the structs that
// join the controller and the datapath.
// ---------------------------------------------------------------------------
package scfp_pkg;

  // Payload store depth, settled by the widths of byte_index and frame_length
  localparam int MAX_PAYLOAD = 64;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_ADDR_W = 1;

  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_B = BYTE_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0]  LEN_SAT       = {LEN_W{1'b1}};

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_HDR  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_HDR = 1'b1;
  localparam logic [BYTE_W-1:0]     FIRST_HDR_RST  = 8'd170;
  localparam logic [BYTE_W-1:0]     SECOND_HDR_RST = 8'd85;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   command;
    logic [LEN_W-1:0]    frame_length;
    logic [IDX_W-1:0]    byte_index;
    logic [BYTE_W-1:0]   data_byte;
    logic                has_data;
    logic                last;
  } result_t;

  // Commands from the controller, each already qualified by its request
  typedef struct packed {
    logic take_cmd;      // command byte accepted
    logic take_len;      // length byte accepted and in range
    logic store_byte;    // payload byte accepted
    logic rd_start;      // checksum good, begin payload readout
    logic rd_advance;    // push one payload result, step the index
    logic push_err_len;  // push length error result
    logic push_chk_bad;  // push checksum mismatch result
    logic push_empty;    // push good result of an empty frame
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_too_big;
    logic in_len_zero;
    logic held_len_zero;
    logic count_done;
    logic sum_match;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/scfp_ram.sv =====
// ---------------------------------------------------------------------------
// scfp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module scfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/scfp_datapath.sv =====
// ---------------------------------------------------------------------------
// scfp_datapath: frame parser datapath
// Header registers, command, length, count and sum registers, payload store
// and the output result register.
// ---------------------------------------------------------------------------
module scfp_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scfp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [scfp_pkg::BYTE_W-1:0]      cfg_wdata,
  input  logic [scfp_pkg::BYTE_W-1:0]      in_byte,
  input  scfp_pkg::ctrl_cmd_t              cmd,
  output scfp_pkg::dp_status_t             st,
  input  logic                             out_ready,
  output logic                             out_valid,
  output scfp_pkg::result_t                out_res
);
  import scfp_pkg::*;

  logic [BYTE_W-1:0] first_hdr;
  logic [BYTE_W-1:0] second_hdr;
  logic [BYTE_W-1:0] held_command;
  logic [LEN_W-1:0]  held_length;
  logic [LEN_W-1:0]  byte_count;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] rd_data;
  logic [LEN_W-1:0]  count_inc;
  logic [LEN_W-1:0]  len_sat;
  logic              push;
  result_t           res_push;

  assign count_inc = byte_count + LEN_W'(1);
  assign len_sat   = (in_byte > BYTE_W'(LEN_SAT)) ? LEN_SAT : in_byte[LEN_W-1:0];

  assign st.hdr1_match    = (in_byte == first_hdr);
  assign st.hdr2_match    = (in_byte == second_hdr);
  assign st.len_too_big   = (in_byte > MAX_PAYLOAD_B);
  assign st.in_len_zero   = (in_byte == '0);
  assign st.held_len_zero = (held_length == '0);
  assign st.count_done    = (count_inc == held_length);
  assign st.sum_match     = (in_byte == running_sum);
  assign st.out_free      = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_hdr  <= FIRST_HDR_RST;
      second_hdr <= SECOND_HDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIRST_HDR:  first_hdr  <= cfg_wdata;
        REG_SECOND_HDR: second_hdr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_command <= '0;
      held_length  <= '0;
      byte_count   <= '0;
      running_sum  <= '0;
    end else begin
      if (cmd.take_cmd) begin
        held_command <= in_byte;
        running_sum  <= in_byte;
      end
      if (cmd.take_len) begin
        held_length <= in_byte[LEN_W-1:0];
        running_sum <= running_sum + in_byte;
        byte_count  <= '0;
      end
      if (cmd.push_err_len) begin
        held_length <= '0;
      end
      if (cmd.store_byte) begin
        running_sum <= running_sum + in_byte;
        byte_count  <= count_inc;
      end
      if (cmd.rd_start) begin
        byte_count <= '0;
      end
      if (cmd.rd_advance) begin
        byte_count <= count_inc;
      end
    end
  end

  scfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (byte_count[IDX_W-1:0]),
    .wdata (in_byte),
    .raddr (byte_count[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign push = cmd.push_err_len | cmd.push_chk_bad | cmd.push_empty | cmd.rd_advance;

  always_comb begin
    res_push              = '0;
    res_push.command      = held_command;
    res_push.frame_length = held_length;
    res_push.last         = 1'b1;
    priority if (cmd.push_err_len) begin
      res_push.status       = ST_LENGTH;
      res_push.frame_length = len_sat;
    end else if (cmd.push_chk_bad) begin
      res_push.status = ST_CHECKSUM;
    end else if (cmd.push_empty) begin
      res_push.status = ST_GOOD;
    end else begin
      res_push.status     = ST_GOOD;
      res_push.byte_index = byte_count[IDX_W-1:0];
      res_push.data_byte  = rd_data;
      res_push.has_data   = 1'b1;
      res_push.last       = st.count_done;
    end
  end

  // Output register: load on push, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res <= res_push;
    end
  end

endmodule

// ===== hdl/scfp_ctrl.sv =====
// ---------------------------------------------------------------------------
// scfp_ctrl: frame parser controller
// Tracks the frame phase and issues datapath commands per accepted byte and during the payload readout.
// ---------------------------------------------------------------------------
module scfp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scfp_pkg::dp_status_t st,
  output scfp_pkg::ctrl_cmd_t  cmd
);
  import scfp_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT1,
    S_HUNT2,
    S_CMD,
    S_LEN,
    S_PAYLOAD,
    S_CHECK,
    S_RD_WAIT,
    S_RD_PUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_HUNT1: begin
        in_ready = 1'b1;
        if (accept && st.hdr1_match) begin
          state_next = S_HUNT2;
        end
      end
      S_HUNT2: begin
        in_ready = 1'b1;
        if (accept) begin
          state_next = st.hdr2_match ? S_CMD : S_HUNT1;
        end
      end
      S_CMD: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.take_cmd = 1'b1;
          state_next   = S_LEN;
        end
      end
      S_LEN: begin
        in_ready = st.out_free;
        if (accept) begin
          if (st.len_too_big) begin
            cmd.push_err_len = 1'b1;
            state_next       = S_HUNT1;
          end else begin
            cmd.take_len = 1'b1;
            state_next   = st.in_len_zero ? S_CHECK : S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.store_byte = 1'b1;
          if (st.count_done) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        in_ready = st.out_free;
        if (accept) begin
          if (!st.sum_match) begin
            cmd.push_chk_bad = 1'b1;
            state_next       = S_HUNT1;
          end else if (st.held_len_zero) begin
            cmd.push_empty = 1'b1;
            state_next     = S_HUNT1;
          end else begin
            cmd.rd_start = 1'b1;
            state_next   = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: begin
        state_next = S_RD_PUSH;
      end
      S_RD_PUSH: begin
        if (st.out_free) begin
          cmd.rd_advance = 1'b1;
          state_next     = st.count_done ? S_HUNT1 : S_RD_WAIT;
        end
      end
      default: state_next = S_HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT1;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/sum_checked_frame_parser.sv =====
// ---------------------------------------------------------------------------
// sum_checked_frame_parser: header, length and checksum frame parser
// Hunts for two configured header bytes in a byte stream and returns the
// payload of each frame whose 8-bit sum checks, or one error result.
// ---------------------------------------------------------------------------
// Each request on the input stream carries one byte and is taken as soon as
// it is offered while the parser hunts for the headers or collects the
// command and payload; the length and checksum bytes wait only if the output
// register still holds a result that nobody has taken. After a good checksum
// the parser stops taking input and reads the payload back from its store:
// each payload byte passes a wait state for the registered read of the
// payload RAM and then a push state that loads the output register once it
// is free, so no new frame is taken before the readout has ended.
// A frame with an empty payload, a checksum mismatch or a length above the
// store depth gives one result with last set. The store needs no clearing
// after reset: only entries written in the current frame are read back.
// ---------------------------------------------------------------------------
module sum_checked_frame_parser (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [scfp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [scfp_pkg::BYTE_W-1:0]      cfg_wdata,
  // Byte stream in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] rx_byte
  // Result stream out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] status, [9:2] command, [16:10] frame_length, [22:17] byte_index,
  // [30:23] data_byte, [31] has_data
  output logic [31:0]                      m_axis_tdata,
  output logic                             m_axis_tlast
);
  import scfp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  result_t    out_res;

  // Sequence the frame phases and the readout
  scfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Hold headers, frame fields, payload and the pending result
  scfp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = {out_res.has_data, out_res.data_byte, out_res.byte_index,
                         out_res.frame_length, out_res.command, out_res.status};
  assign m_axis_tlast = out_res.last;

  // Error results stand alone
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_res.status != ST_GOOD) |-> m_axis_tlast && !out_res.has_data)
    else $error("error result not a single result");

  // A result with no data always closes its run
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.has_data |-> m_axis_tlast)
    else $error("result without data does not close its run");

  // Payload results lie inside the frame
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_res.has_data |->
      (LEN_W'(out_res.byte_index) < out_res.frame_length) && (out_res.status == ST_GOOD))
    else $error("payload index outside the frame");

  // A payload readout, once started, opens with input ready low
  a_no_input_in_readout: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_start |=> !s_axis_tready)
    else $error("input taken during readout");

endmodule
